/* src/sssc_pkg.sv */
// Shared types, constants and the segment table of the seven-segment number scanner.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package sssc_pkg;

    // Magnitude width and the BCD digits needed to hold it
    localparam int MAG_W      = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CNT_W      = $clog2(MAG_W + 1);
    localparam int ND_W       = 4;

    localparam int DIGITS_DEFAULT = 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_COMMON_CATHODE    = 2'd0;
    localparam logic [1:0] CFG_DRIVE_ACTIVE_HIGH = 2'd1;
    localparam logic [1:0] CFG_DECIMALS          = 2'd2;

    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] SEG_POINT = 8'h80;
    localparam logic [7:0] SEG_DARK  = 8'h00;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } t_state;

    // Per-frame facts handed from the control to the emitter
    typedef struct packed {
        logic            neg;
        logic            fits;
        logic [ND_W-1:0] nd;
        logic [1:0]      dec;
    } t_frame;

    function automatic logic [7:0] seg_of_digit(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h67;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

/* src/sssc_dabble.sv */
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit per cycle.
// Depends on sssc_pkg.
`default_nettype none

module sssc_dabble (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [sssc_pkg::MAG_W-1:0]  i_mag,
    output logic                             o_done,
    output logic [sssc_pkg::BCD_W-1:0]       o_bcd
);

    logic [sssc_pkg::MAG_W-1:0] r_bin;
    logic [sssc_pkg::BCD_W-1:0] r_bcd;
    logic [sssc_pkg::CNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [sssc_pkg::BCD_W-1:0] adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < sssc_pkg::BCD_DIGITS; k++) begin
            if (r_bcd[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = r_bcd[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = r_bcd[4*k +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == sssc_pkg::CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= sssc_pkg::CNT_W'(sssc_pkg::MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - sssc_pkg::CNT_W'(1);
                if (r_cnt == sssc_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_mag;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[sssc_pkg::MAG_W-2:0], 1'b0};
            r_bcd <= {adj[sssc_pkg::BCD_W-2:0], r_bin[sssc_pkg::MAG_W-1]};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

`default_nettype wire

/* src/sssc_emit.sv */
// Frame emitter: shifts out one BCD digit per result and forms the scan result.
// Depends on sssc_pkg.
`default_nettype none

module sssc_emit #(
    parameter int DIGITS = sssc_pkg::DIGITS_DEFAULT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire sssc_pkg::t_frame      i_frame,
    input  wire logic [4*DIGITS-1:0]   i_digits,
    input  wire logic                  i_common_cathode,
    input  wire logic                  i_drive_active_high,
    input  wire logic                  i_ready,
    output logic                       o_valid,
    output logic [1:0]                 o_position,
    output logic [7:0]                 o_segments,
    output logic                       o_digit_drive,
    output logic                       o_lit,
    output logic                       o_overflow,
    output logic                       o_last,
    output logic                       o_done
);

    localparam int PW = $clog2(DIGITS);

    logic                 r_valid;
    logic [PW-1:0]        r_pos;
    logic [4*DIGITS-1:0]  r_digits;
    sssc_pkg::t_frame     r_frame;
    logic                 last;
    logic                 take;
    logic [sssc_pkg::ND_W-1:0] pos_w;
    logic [7:0]           seg_raw;
    logic                 lit;

    assign last  = (r_pos == PW'(DIGITS - 1));
    assign take  = r_valid && i_ready;
    assign pos_w = sssc_pkg::ND_W'(r_pos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_pos   <= '0;
        end else if (take) begin
            r_pos <= r_pos + PW'(1);
            if (last) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_digits <= i_digits;
            r_frame  <= i_frame;
        end else if (take) begin
            r_digits <= r_digits >> 4;
        end
    end

    always_comb begin
        if (!r_frame.fits) begin
            seg_raw = sssc_pkg::SEG_MINUS;
            lit     = 1'b1;
        end else if (pos_w < r_frame.nd) begin
            seg_raw = sssc_pkg::seg_of_digit(r_digits[3:0]);
            if ((r_frame.dec != 2'd0) && (pos_w == sssc_pkg::ND_W'(r_frame.dec))) begin
                seg_raw = seg_raw | sssc_pkg::SEG_POINT;
            end
            lit = 1'b1;
        end else if (r_frame.neg && (pos_w == r_frame.nd)) begin
            seg_raw = sssc_pkg::SEG_MINUS;
            lit     = 1'b1;
        end else begin
            seg_raw = sssc_pkg::SEG_DARK;
            lit     = 1'b0;
        end
    end

    assign o_valid       = r_valid;
    assign o_position    = 2'(r_pos);
    assign o_segments    = i_common_cathode ? seg_raw : ~seg_raw;
    assign o_digit_drive = lit ? i_drive_active_high : ~i_drive_active_high;
    assign o_lit         = lit;
    assign o_overflow    = ~r_frame.fits;
    assign o_last        = last;
    assign o_done        = take && last;

endmodule

`default_nettype wire

/* src/seven_segment_number_scanner_unit.sv */
// Top level of the seven-segment number scanner: control, configuration, converter, emitter.
// Depends on sssc_pkg, sssc_dabble and sssc_emit.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------------
//  input    | i_valid / o_ready  | i_value (signed 32)
//  output   | o_valid / i_ready  | o_position, o_segments, o_digit_drive, o_lit,
//           |                    | o_overflow, o_last
//  config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// An item first goes through the bit-serial shift-and-add-3 converter, one magnitude bit
// per cycle; its frame then shows one result per cycle while the sink is ready.
// Reset (synchronous, active low) empties the pipeline and loads the register defaults:
// common cathode, digit drive active low, no decimals.
// A stalled sink holds the current result; a new item is taken only once the frame
// of the previous item has been fully delivered.
`default_nettype none

module seven_segment_number_scanner_unit #(
    parameter int DIGITS = sssc_pkg::DIGITS_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input items
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic signed [31:0]  i_value,
    // result items
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [1:0]               o_position,
    output logic [7:0]               o_segments,
    output logic                     o_digit_drive,
    output logic                     o_lit,
    output logic                     o_overflow,
    output logic                     o_last,
    // configuration writes
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [1:0]          i_cfg_data
);

    localparam int DMAX = DIGITS - 1;

    sssc_pkg::t_state r_state;
    sssc_pkg::t_state n_state;

    logic       r_common_cathode;
    logic       r_drive_active_high;
    logic [1:0] r_decimals;
    logic       r_neg;

    logic                             accept;
    logic                             load;
    logic                             conv_done;
    logic                             frame_done;
    logic [sssc_pkg::MAG_W-1:0]       mag;
    logic [sssc_pkg::BCD_W-1:0]       bcd;
    logic [sssc_pkg::ND_W-1:0]        nd;
    logic [sssc_pkg::ND_W-1:0]        nd_eff;
    logic [1:0]                       dec_sat;
    sssc_pkg::t_frame                 frame;

    assign accept = i_valid && o_ready;

    // Magnitude of the two's complement input; the most negative value maps to 2^31
    assign mag = i_value[31] ? (~i_value + 32'd1) : i_value;

    // Configuration registers; writes to an unused index are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_common_cathode    <= 1'b1;
            r_drive_active_high <= 1'b0;
            r_decimals          <= 2'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sssc_pkg::CFG_COMMON_CATHODE:    r_common_cathode    <= i_cfg_data[0];
                sssc_pkg::CFG_DRIVE_ACTIVE_HIGH: r_drive_active_high <= i_cfg_data[0];
                sssc_pkg::CFG_DECIMALS:          r_decimals          <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the sign of the item under conversion
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg <= i_value[31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sssc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sssc_pkg::ST_IDLE: if (accept)     n_state = sssc_pkg::ST_CONV;
            sssc_pkg::ST_CONV: if (conv_done)  n_state = sssc_pkg::ST_EMIT;
            sssc_pkg::ST_EMIT: if (frame_done) n_state = sssc_pkg::ST_IDLE;
            default:                           n_state = sssc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        load    = 1'b0;
        case (r_state)
            sssc_pkg::ST_IDLE: o_ready = 1'b1;
            sssc_pkg::ST_CONV: load    = conv_done;
            sssc_pkg::ST_EMIT: ;
            default: ;
        endcase
    end

    sssc_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_mag   (mag),
        .o_done  (conv_done),
        .o_bcd   (bcd)
    );

    // Count the decimal digits: top nonzero BCD digit, at least one
    always_comb begin
        nd = sssc_pkg::ND_W'(1);
        for (int k = 1; k < sssc_pkg::BCD_DIGITS; k++) begin
            if (bcd[4*k +: 4] != 4'd0) begin
                nd = sssc_pkg::ND_W'(k + 1);
            end
        end
    end

    // Clamp decimals to the display, then force a leading zero before the point
    assign dec_sat = (32'(r_decimals) > DMAX) ? 2'(DMAX) : r_decimals;
    assign nd_eff  = (nd < (sssc_pkg::ND_W'(dec_sat) + sssc_pkg::ND_W'(1)))
                   ? (sssc_pkg::ND_W'(dec_sat) + sssc_pkg::ND_W'(1)) : nd;

    always_comb begin
        frame.neg  = r_neg;
        frame.nd   = nd_eff;
        frame.dec  = dec_sat;
        frame.fits = (5'(nd_eff) + 5'(r_neg)) <= 5'(DIGITS);
    end

    sssc_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_load              (load),
        .i_frame             (frame),
        .i_digits            (bcd[4*DIGITS-1:0]),
        .i_common_cathode    (r_common_cathode),
        .i_drive_active_high (r_drive_active_high),
        .i_ready             (i_ready),
        .o_valid             (o_valid),
        .o_position          (o_position),
        .o_segments          (o_segments),
        .o_digit_drive       (o_digit_drive),
        .o_lit               (o_lit),
        .o_overflow          (o_overflow),
        .o_last              (o_last),
        .o_done              (frame_done)
    );

    // Results appear only while a frame is being emitted
    a_valid_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == sssc_pkg::ST_EMIT))
        else $error("result valid outside of frame emission");

    // The converter finishes only while the control waits for it
    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_done |-> (r_state == sssc_pkg::ST_CONV))
        else $error("converter finished outside of conversion");

    // Delivering the last result of a frame ends the frame
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> (!o_valid && o_ready))
        else $error("frame did not end after its last result");

    // An overflowing frame lights every position
    a_ovf_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> o_lit)
        else $error("overflow result not lit");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Testbench for the seven-segment number scanner: drives signed values, predicts every
// scan frame from a behavioral model of its own and checks each result field by field.
// Depends on sssc_pkg and seven_segment_number_scanner_unit.
`default_nettype none

module tb_top;

    localparam int DIGITS = sssc_pkg::DIGITS_DEFAULT;
    // Conversion plus one full frame, with margin: how long a frame can still be in flight
    localparam int FRAME_CYCLES = 34 + DIGITS + 16;
    // Cycles without a handshake on either channel before the run is declared hung
    localparam int HANG_LIMIT = 4000;
    localparam int REPORT_MAX = 10;

    // Segment patterns of the decimal digits, bit0 = a .. bit6 = g
    localparam logic [7:0] DIGIT_GLYPH [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67
    };
    localparam int unsigned POW10 [6] = '{1, 10, 100, 1000, 10000, 100000};

    typedef struct packed {
        logic [1:0] position;
        logic [7:0] segments;
        logic       digit_drive;
        logic       lit;
        logic       overflow;
        logic       last;
    } t_scan_result;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic signed [31:0] i_value       = '0;
    logic               i_ready       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [1:0]         i_cfg_index   = '0;
    logic [1:0]         i_cfg_data    = '0;
    logic               o_ready;
    logic               o_valid;
    logic [1:0]         o_position;
    logic [7:0]         o_segments;
    logic               o_digit_drive;
    logic               o_lit;
    logic               o_overflow;
    logic               o_last;

    // Display setting as the block holds it, tracked at every register write
    logic       cfg_common_cathode = 1'b1;
    logic       cfg_drive_high     = 1'b0;
    logic [1:0] cfg_decimals       = 2'd0;

    t_scan_result pending_scans [$];
    int           fail_cnt      = 0;
    int           src_idle_pct  = 0;
    int           snk_stall_pct = 0;

    seven_segment_number_scanner_unit #(
        .DIGITS(DIGITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_position    (o_position),
        .o_segments    (o_segments),
        .o_digit_drive (o_digit_drive),
        .o_lit         (o_lit),
        .o_overflow    (o_overflow),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side at random; a zero percentage keeps it always ready
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Work out the whole scan frame that one value produces and queue it
    function automatic void predict_frame(input logic signed [31:0] value);
        t_scan_result r;
        logic         neg;
        logic         fits;
        logic         shown;
        logic [32:0]  mag;
        logic [32:0]  rest;
        logic [7:0]   glyph;
        int unsigned  dec;
        int unsigned  ndig;
        neg = value[31];
        // The magnitude is worked out in 33 bits; the most negative value gives 2^31
        mag = neg ? ({1'b0, ~value} + 33'd1) : {1'b0, value};
        dec = (cfg_decimals > DIGITS - 1) ? DIGITS - 1 : cfg_decimals;
        ndig = 1;
        rest = mag;
        while (rest >= 10) begin
            rest = rest / 10;
            ndig++;
        end
        // Keep a leading zero before the point and the zeros inside the fraction
        if (ndig < dec + 1)
            ndig = dec + 1;
        fits = (ndig + neg) <= DIGITS;
        rest = mag;
        for (int p = 0; p < DIGITS; p++) begin
            shown = 1'b1;
            if (!fits) begin
                glyph = sssc_pkg::SEG_MINUS;
            end else if (p < ndig) begin
                glyph = DIGIT_GLYPH[rest % 10];
                rest  = rest / 10;
                if (dec > 0 && p == dec)
                    glyph = glyph | sssc_pkg::SEG_POINT;
            end else if (neg && p == ndig) begin
                glyph = sssc_pkg::SEG_MINUS;
            end else begin
                glyph = sssc_pkg::SEG_DARK;
                shown = 1'b0;
            end
            r.position    = 2'(p);
            r.segments    = cfg_common_cathode ? glyph : ~glyph;
            r.digit_drive = shown ? cfg_drive_high : ~cfg_drive_high;
            r.lit         = shown;
            r.overflow    = !fits;
            r.last        = (p == DIGITS - 1);
            pending_scans.push_back(r);
        end
    endfunction

    // Compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_scan_result got;
        t_scan_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_position, o_segments, o_digit_drive, o_lit, o_overflow, o_last};
            if (pending_scans.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= REPORT_MAX)
                    $display("unexpected: pos %0d seg %02h drv %b lit %b ovf %b last %b",
                             got.position, got.segments, got.digit_drive, got.lit,
                             got.overflow, got.last);
            end else begin
                want = pending_scans.pop_front();
                if (got.position !== want.position || got.segments !== want.segments ||
                    got.digit_drive !== want.digit_drive || got.lit !== want.lit ||
                    got.overflow !== want.overflow || got.last !== want.last) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX) begin
                        $display("expected: pos %0d seg %02h drv %b lit %b ovf %b last %b",
                                 want.position, want.segments, want.digit_drive,
                                 want.lit, want.overflow, want.last);
                        $display("actual:   pos %0d seg %02h drv %b lit %b ovf %b last %b",
                                 got.position, got.segments, got.digit_drive,
                                 got.lit, got.overflow, got.last);
                    end
                end
            end
        end
    end

    // Drop out of the run once nothing has moved on either channel for too long
    initial begin : hang_watch
        int quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    // Offer one value, after a random gap, and hold it until the block takes it.
    // Valid stays high on return so that a following item can go back to back.
    task automatic show_value(input logic signed [31:0] value);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predict_frame(value);
    endtask

    // Drop valid and hold off until every frame in flight has been delivered
    task automatic wait_display_idle();
        i_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_scans.size() != 0);
    endtask

    // Write all three registers on consecutive cycles; call only while idle
    task automatic set_display(input logic cc, input logic drive_high, input logic [1:0] dec);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sssc_pkg::CFG_COMMON_CATHODE;
        i_cfg_data  <= {1'b0, cc};
        @(posedge i_clk);
        i_cfg_index <= sssc_pkg::CFG_DRIVE_ACTIVE_HIGH;
        i_cfg_data  <= {1'b0, drive_high};
        @(posedge i_clk);
        i_cfg_index <= sssc_pkg::CFG_DECIMALS;
        i_cfg_data  <= dec;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_common_cathode = cc;
        cfg_drive_high     = drive_high;
        cfg_decimals       = dec;
    endtask

    // Mostly values near the display capacity, some right at a digit-count boundary,
    // and some arbitrary 32-bit patterns
    function automatic logic signed [31:0] random_value();
        logic [31:0] mag;
        int unsigned span;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return $urandom;
        span = POW10[$urandom_range(5, 1)];
        if (pick < 30)
            mag = pick[0] ? span : span - 1;
        else
            mag = $urandom_range(span - 1);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // Reset setting: common cathode, low-active drive, integers only
    task automatic test_default_setting();
        logic signed [31:0] vals [7] = '{0, 7, -7, 9999, -999, 10000, -1000};
        foreach (vals[k])
            show_value(vals[k]);
    endtask

    // Largest magnitudes, including the one without a positive counterpart
    task automatic test_full_range_values();
        logic signed [31:0] vals [4] = '{32'sh7FFF_FFFF, -32'sh7FFF_FFFF,
                                        32'sh8000_0000, 1};
        wait_display_idle();
        set_display(1'b0, 1'b1, 2'd0);
        foreach (vals[k])
            show_value(vals[k]);
    endtask

    // Point placement, leading zero before the point, and signs that no longer fit
    task automatic test_fraction_digits();
        logic signed [31:0] three [6] = '{0, 5, 999, -5, -123, 1234};
        logic signed [31:0] one [3]   = '{5, -99, -1};
        logic signed [31:0] two [3]   = '{7, -12, 9999};
        wait_display_idle();
        set_display(1'b0, 1'b1, 2'd3);
        foreach (three[k])
            show_value(three[k]);
        wait_display_idle();
        set_display(1'b1, 1'b1, 2'd1);
        foreach (one[k])
            show_value(one[k]);
        wait_display_idle();
        set_display(1'b0, 1'b0, 2'd2);
        foreach (two[k])
            show_value(two[k]);
    endtask

    // Random values under a new random setting every few dozen items, with an
    // occasional pause until the display has caught up
    task automatic run_random_values(input int n_items, input int src_pct, input int snk_pct);
        int sent;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        sent = 0;
        while (sent < n_items) begin
            if (sent % 32 == 0) begin
                wait_display_idle();
                set_display(1'($urandom_range(1)), 1'($urandom_range(1)),
                            2'($urandom_range(3)));
            end else if ($urandom_range(39) == 0) begin
                wait_display_idle();
            end
            show_value(random_value());
            sent++;
        end
    endtask

    task automatic test_random_slow_sink();
        run_random_values(115, 8, 87);
    endtask

    task automatic test_random_slow_source();
        run_random_values(115, 87, 8);
    endtask

    task automatic test_random_full_rate();
        run_random_values(115, 0, 0);
    endtask

    initial begin
        src_idle_pct  = 8;
        snk_stall_pct = 87;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_setting();
        test_full_range_values();
        test_fraction_digits();
        test_random_slow_sink();
        test_random_slow_source();
        test_random_full_rate();

        // Drain, then give a stray extra result time to show up
        wait_display_idle();
        repeat (FRAME_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && pending_scans.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
src/sssc_pkg.sv
src/sssc_dabble.sv
src/sssc_emit.sv
src/seven_segment_number_scanner_unit.sv
sim/tb_top.sv
